// ===== src/bis_pkg.sv =====
// Shared constants, types and arithmetic helpers of the bilinear image scaler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package bis_pkg;

  localparam int MAX_SRC_WIDTH  = 512;
  localparam int MAX_SRC_HEIGHT = 512;
  localparam int FRAC_BITS      = 16;

  localparam int SZ_W   = 10;   // source size registers
  localparam int DST_W  = 13;   // destination size registers
  localparam int LD_W   = 9;    // load coordinates
  localparam int OUT_W  = 12;   // destination coordinates
  localparam int PIX_W  = 8;

  localparam int SRC_MAX   = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
  localparam int SRC_IDX_W = $clog2(SRC_MAX);
  localparam int CMP_W     = (SZ_W > SRC_IDX_W) ? SZ_W : SRC_IDX_W;

  // Four banks split by row and column parity; one bank entry per pixel.
  localparam int BANK_AW    = 2 * (SRC_IDX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Divider widths: numerator is (coordinate * size) << FRAC_BITS.
  localparam int A_W = OUT_W + SZ_W;
  localparam int N_W = A_W + FRAC_BITS;
  localparam int Q_W = SRC_IDX_W + FRAC_BITS;

  // Blend arithmetic widths.
  localparam int PROD_W = PIX_W + 1 + FRAC_BITS + 1;
  localparam int RND_W  = PROD_W + 1 - FRAC_BITS;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 8;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [LD_W-1:0]   lrow;
    logic [LD_W-1:0]   lcol;
    logic [PIX_W-1:0]  lpix;
    logic              err;
    logic [SZ_W-1:0]   sw;
    logic [SZ_W-1:0]   sh;
  } item_t;

  typedef struct packed {
    logic valid;
    logic op;
    logic err;
  } blend_ctl_t;

  function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v, input int maxv);
    logic [SZ_W-1:0] r;
    r = v;
    if (v < SZ_W'(2)) r = SZ_W'(2);
    else if (int'(v) > maxv) r = SZ_W'(maxv);
    return r;
  endfunction

  // (v1 - v0) * f, signed.
  function automatic logic signed [PROD_W-1:0] blend_prod(input logic [PIX_W-1:0] v0,
                                                          input logic [PIX_W-1:0] v1,
                                                          input logic [FRAC_BITS-1:0] f);
    logic signed [PIX_W:0]      diff;
    logic signed [FRAC_BITS:0]  fs;
    diff = $signed({1'b0, v1}) - $signed({1'b0, v0});
    fs   = $signed({1'b0, f});
    return PROD_W'(diff * fs);
  endfunction

  // v0 + round half up (prod / 2^FRAC_BITS), saturated to 0..255.
  function automatic logic [PIX_W-1:0] blend_fin(input logic [PIX_W-1:0] v0,
                                                 input logic signed [PROD_W-1:0] prod);
    logic [PROD_W:0]  t;
    logic [RND_W-1:0] r;
    logic [RND_W:0]   v;
    logic [PIX_W-1:0] res;
    t = {prod[PROD_W-1], prod} + (PROD_W+1)'(1 << (FRAC_BITS - 1));
    r = t[PROD_W:FRAC_BITS];
    v = {r[RND_W-1], r} + {{(RND_W+1-PIX_W){1'b0}}, v0};
    if (v[RND_W]) res = '0;
    else if (v[RND_W-1:PIX_W] != '0) res = '1;
    else res = v[PIX_W-1:0];
    return res;
  endfunction

endpackage

// ===== src/bilinear_image_scaler_top.sv =====
// Bilinear image scaler: a compute transaction passes the 25-stage coordinate divider,
// the bank read and the 4-stage blend on its way to the result; loads give no result.
// One transaction per cycle is taken, loads and computes alike, unless the skid is full.
// Reset clears the control state and sets the sizes to 512 x 512 source, 1024 x 1024
// destination; the frame store is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
module bilinear_image_scaler_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // load_row [8:0], load_col [17:9], load_pixel [25:18], out_row [37:26], out_col [49:38]
  input  logic [bis_pkg::S_TDATA_W-1:0]     s_tdata,
  // operation [0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // pixel_value [7:0]
  output logic [bis_pkg::M_TDATA_W-1:0]     m_tdata,
  // coord_error [0]
  output logic                              m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bis_pkg::APB_AW-1:0]        paddr,
  input  logic [bis_pkg::APB_DW-1:0]        pwdata,
  output logic [bis_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int IW = bis_pkg::SRC_IDX_W;
  localparam int FB = bis_pkg::FRAC_BITS;

  // Configuration registers.
  logic [bis_pkg::SZ_W-1:0]  src_width, src_height;
  logic [bis_pkg::DST_W-1:0] dst_width, dst_height;
  bis_pkg::reg_idx_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = bis_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bis_pkg::SZ_W'(512);
      src_height <= bis_pkg::SZ_W'(512);
      dst_width  <= bis_pkg::DST_W'(1024);
      dst_height <= bis_pkg::DST_W'(1024);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        bis_pkg::REG_SRC_WIDTH:  src_width  <= pwdata[bis_pkg::SZ_W-1:0];
        bis_pkg::REG_SRC_HEIGHT: src_height <= pwdata[bis_pkg::SZ_W-1:0];
        bis_pkg::REG_DST_WIDTH:  dst_width  <= pwdata[bis_pkg::DST_W-1:0];
        bis_pkg::REG_DST_HEIGHT: dst_height <= pwdata[bis_pkg::DST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bis_pkg::REG_SRC_WIDTH:  prdata = bis_pkg::APB_DW'(src_width);
      bis_pkg::REG_SRC_HEIGHT: prdata = bis_pkg::APB_DW'(src_height);
      bis_pkg::REG_DST_WIDTH:  prdata = bis_pkg::APB_DW'(dst_width);
      bis_pkg::REG_DST_HEIGHT: prdata = bis_pkg::APB_DW'(dst_height);
      default:                 prdata = '0;
    endcase
  end

  // Whole pipeline advances together; it halts only while the skid register is full.
  logic skid_valid;
  logic en;
  assign en       = !skid_valid;
  assign s_tready = en;

  // Entry stage: unpack, range check, clamp and multiply.
  logic [bis_pkg::OUT_W-1:0] in_orow, in_ocol;
  logic [bis_pkg::SZ_W-1:0]  in_sw, in_sh;
  bis_pkg::item_t            in_item;

  assign in_orow = s_tdata[37:26];
  assign in_ocol = s_tdata[49:38];
  assign in_sw   = bis_pkg::clamp_size(src_width, bis_pkg::MAX_SRC_WIDTH);
  assign in_sh   = bis_pkg::clamp_size(src_height, bis_pkg::MAX_SRC_HEIGHT);

  always_comb begin
    in_item.op   = s_tuser;
    in_item.lrow = s_tdata[8:0];
    in_item.lcol = s_tdata[17:9];
    in_item.lpix = s_tdata[25:18];
    in_item.err  = ({1'b0, in_ocol} >= dst_width) || ({1'b0, in_orow} >= dst_height);
    in_item.sw   = in_sw;
    in_item.sh   = in_sh;
  end

  logic                        s0_valid;
  bis_pkg::item_t              s0_item;
  logic [bis_pkg::A_W-1:0]     s0_ax, s0_ay;
  logic [bis_pkg::DST_W-1:0]   s0_dw, s0_dh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_tvalid;
    end
    if (en) begin
      s0_item <= in_item;
      s0_ax   <= bis_pkg::A_W'(in_ocol) * bis_pkg::A_W'(in_sw);
      s0_ay   <= bis_pkg::A_W'(in_orow) * bis_pkg::A_W'(in_sh);
      s0_dw   <= dst_width;
      s0_dh   <= dst_height;
    end
  end

  logic                      dv_valid;
  bis_pkg::item_t            dv_item;
  logic [bis_pkg::Q_W-1:0]   dv_qx, dv_qy;

  bis_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .in_item   (s0_item),
    .in_ax     (s0_ax),
    .in_ay     (s0_ay),
    .in_dw     (s0_dw),
    .in_dh     (s0_dh),
    .out_valid (dv_valid),
    .out_item  (dv_item),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy)
  );

  // Edge stage: step back one whole pixel at or past the last column or row.
  logic [IW-1:0]            ipx, ipy;
  logic                     bx, by;
  assign ipx = dv_qx[bis_pkg::Q_W-1:FB];
  assign ipy = dv_qy[bis_pkg::Q_W-1:FB];
  assign bx  = bis_pkg::CMP_W'(ipx) >= (bis_pkg::CMP_W'(dv_item.sw) - bis_pkg::CMP_W'(1));
  assign by  = bis_pkg::CMP_W'(ipy) >= (bis_pkg::CMP_W'(dv_item.sh) - bis_pkg::CMP_W'(1));

  logic                     ad_valid;
  bis_pkg::item_t           ad_item;
  logic [IW-1:0]            ad_ix, ad_iy;
  logic [FB-1:0]            ad_fx, ad_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ad_valid <= 1'b0;
    end else if (en) begin
      ad_valid <= dv_valid;
    end
    if (en) begin
      ad_item <= dv_item;
      ad_ix   <= bx ? ipx - IW'(1) : ipx;
      ad_iy   <= by ? ipy - IW'(1) : ipy;
      ad_fx   <= dv_qx[FB-1:0];
      ad_fy   <= dv_qy[FB-1:0];
    end
  end

  // Loads write at the same stage where computes read, so store accesses keep
  // transaction order without any forwarding.
  logic st_wr;
  assign st_wr = ad_valid && ad_item.op == bis_pkg::OP_LOAD
              && int'(ad_item.lrow) < bis_pkg::MAX_SRC_HEIGHT
              && int'(ad_item.lcol) < bis_pkg::MAX_SRC_WIDTH;

  logic [bis_pkg::PIX_W-1:0] pa, pb, pc, pd;

  bis_store u_store (
    .clk   (clk),
    .en    (en),
    .wr    (st_wr),
    .wrow  (IW'(ad_item.lrow)),
    .wcol  (IW'(ad_item.lcol)),
    .wdata (ad_item.lpix),
    .iy    (ad_iy),
    .ix    (ad_ix),
    .pa    (pa),
    .pb    (pb),
    .pc    (pc),
    .pd    (pd)
  );

  bis_pkg::blend_ctl_t rd_ctl;
  logic [FB-1:0]       rd_fx, rd_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl.valid <= 1'b0;
    end else if (en) begin
      rd_ctl.valid <= ad_valid;
    end
    if (en) begin
      rd_ctl.op  <= ad_item.op;
      rd_ctl.err <= ad_item.err;
      rd_fx      <= ad_fx;
      rd_fy      <= ad_fy;
    end
  end

  logic                      bl_valid, bl_err;
  logic [bis_pkg::PIX_W-1:0] bl_pixel;

  bis_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctl    (rd_ctl),
    .pa        (pa),
    .pb        (pb),
    .pc        (pc),
    .pd        (pd),
    .fx        (rd_fx),
    .fy        (rd_fy),
    .out_valid (bl_valid),
    .out_pixel (bl_pixel),
    .out_err   (bl_err)
  );

  // Output register with one skid entry behind it.
  logic                      out_take;
  logic [bis_pkg::PIX_W-1:0] skid_pixel;
  logic                      skid_err;
  assign out_take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!en) begin
      if (out_take) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= skid_pixel;
        m_tuser    <= skid_err;
        skid_valid <= 1'b0;
      end
    end else if (bl_valid) begin
      if (out_take) begin
        m_tvalid <= 1'b1;
        m_tdata  <= bl_pixel;
        m_tuser  <= bl_err;
      end else begin
        skid_valid <= 1'b1;
        skid_pixel <= bl_pixel;
        skid_err   <= bl_err;
      end
    end else if (out_take) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== src/bis_div.sv =====
// Pipelined restoring divider for both source coordinates, one quotient bit per stage.
// Carries the item payload alongside; depends on bis_pkg.
`timescale 1ns / 1ps
module bis_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  bis_pkg::item_t               in_item,
  input  logic [bis_pkg::A_W-1:0]      in_ax,
  input  logic [bis_pkg::A_W-1:0]      in_ay,
  input  logic [bis_pkg::DST_W-1:0]    in_dw,
  input  logic [bis_pkg::DST_W-1:0]    in_dh,
  output logic                         out_valid,
  output bis_pkg::item_t               out_item,
  output logic [bis_pkg::Q_W-1:0]      out_qx,
  output logic [bis_pkg::Q_W-1:0]      out_qy
);

  localparam int QW = bis_pkg::Q_W;
  localparam int NW = bis_pkg::N_W;
  localparam int DW = bis_pkg::DST_W;

  logic                vld  [QW+1];
  bis_pkg::item_t      itm  [QW+1];
  logic [NW-1:0]       nx   [QW+1];
  logic [NW-1:0]       ny   [QW+1];
  logic [DW-1:0]       dx   [QW+1];
  logic [DW-1:0]       dy   [QW+1];
  logic [DW-1:0]       rx   [QW+1];
  logic [DW-1:0]       ry   [QW+1];
  logic [QW-1:0]       qx   [QW+1];
  logic [QW-1:0]       qy   [QW+1];

  assign vld[0] = in_valid;
  assign itm[0] = in_item;
  assign nx[0]  = {in_ax, {bis_pkg::FRAC_BITS{1'b0}}};
  assign ny[0]  = {in_ay, {bis_pkg::FRAC_BITS{1'b0}}};
  assign dx[0]  = in_dw;
  assign dy[0]  = in_dh;
  // The coordinate is below the destination size, so the quotient fits QW bits
  // and the bits above QW start the remainder.
  assign rx[0]  = DW'(nx[0] >> QW);
  assign ry[0]  = DW'(ny[0] >> QW);
  assign qx[0]  = '0;
  assign qy[0]  = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] sx, sy, tx, ty;
    logic        gx, gy;

    always_comb begin
      sx = {rx[k], nx[k][QW-1-k]};
      sy = {ry[k], ny[k][QW-1-k]};
      gx = (sx >= {1'b0, dx[k]});
      gy = (sy >= {1'b0, dy[k]});
      tx = gx ? (sx - {1'b0, dx[k]}) : sx;
      ty = gy ? (sy - {1'b0, dy[k]}) : sy;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        itm[k+1] <= itm[k];
        nx[k+1]  <= nx[k];
        ny[k+1]  <= ny[k];
        dx[k+1]  <= dx[k];
        dy[k+1]  <= dy[k];
        rx[k+1]  <= tx[DW-1:0];
        ry[k+1]  <= ty[DW-1:0];
        qx[k+1]  <= {qx[k][QW-2:0], gx};
        qy[k+1]  <= {qy[k][QW-2:0], gy};
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_item  = itm[QW];
  assign out_qx    = qx[QW];
  assign out_qy    = qy[QW];

endmodule

// ===== src/bis_store.sv =====
// Source frame store: four banks split by row and column parity, so that the four
// neighbours of a position are read in the same cycle. Depends on bis_pkg.
`timescale 1ns / 1ps
module bis_store (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            wr,
  input  logic [bis_pkg::SRC_IDX_W-1:0]   wrow,
  input  logic [bis_pkg::SRC_IDX_W-1:0]   wcol,
  input  logic [bis_pkg::PIX_W-1:0]       wdata,
  input  logic [bis_pkg::SRC_IDX_W-1:0]   iy,
  input  logic [bis_pkg::SRC_IDX_W-1:0]   ix,
  output logic [bis_pkg::PIX_W-1:0]       pa,
  output logic [bis_pkg::PIX_W-1:0]       pb,
  output logic [bis_pkg::PIX_W-1:0]       pc,
  output logic [bis_pkg::PIX_W-1:0]       pd
);

  localparam int IW = bis_pkg::SRC_IDX_W;
  localparam int HW = IW - 1;

  logic [IW-1:0]              iy1, ix1;
  logic [bis_pkg::PIX_W-1:0]  rdata [4];
  logic                       py, px;

  assign iy1 = iy + IW'(1);
  assign ix1 = ix + IW'(1);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic RB = k[1];
    localparam logic CB = k[0];
    logic [bis_pkg::PIX_W-1:0]   mem [bis_pkg::BANK_DEPTH];
    logic [IW-1:0]               rr, rc;
    logic [bis_pkg::BANK_AW-1:0] raddr, waddr;

    // Of the two rows (columns) needed, exactly one has this bank's parity.
    assign rr    = (iy[0] == RB) ? iy : iy1;
    assign rc    = (ix[0] == CB) ? ix : ix1;
    assign raddr = {rr[IW-1:1], rc[IW-1:1]};
    assign waddr = {wrow[IW-1:1], wcol[IW-1:1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (wr && wrow[0] == RB && wcol[0] == CB) begin
          mem[waddr] <= wdata;
        end
        rdata[k] <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      py <= iy[0];
      px <= ix[0];
    end
  end

  assign pa = rdata[{py, px}];
  assign pb = rdata[{~py, px}];
  assign pc = rdata[{py, ~px}];
  assign pd = rdata[{~py, ~px}];

endmodule

// ===== src/bis_blend.sv =====
// Four-stage blend pipeline: two vertical blends, then one horizontal blend,
// each as a registered product followed by round and saturate. Depends on bis_pkg.
`timescale 1ns / 1ps
module bis_blend (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  bis_pkg::blend_ctl_t              in_ctl,
  input  logic [bis_pkg::PIX_W-1:0]        pa,
  input  logic [bis_pkg::PIX_W-1:0]        pb,
  input  logic [bis_pkg::PIX_W-1:0]        pc,
  input  logic [bis_pkg::PIX_W-1:0]        pd,
  input  logic [bis_pkg::FRAC_BITS-1:0]    fx,
  input  logic [bis_pkg::FRAC_BITS-1:0]    fy,
  output logic                             out_valid,
  output logic [bis_pkg::PIX_W-1:0]        out_pixel,
  output logic                             out_err
);

  bis_pkg::blend_ctl_t                    c1, c2, c3;
  logic signed [bis_pkg::PROD_W-1:0]      p1, p2, p3;
  logic [bis_pkg::PIX_W-1:0]              a1, c1v, m1, m2, m1d;
  logic [bis_pkg::FRAC_BITS-1:0]          fx1, fx2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid  <= 1'b0;
      c2.valid  <= 1'b0;
      c3.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c1.valid  <= in_ctl.valid && in_ctl.op == bis_pkg::OP_COMPUTE;
      c2.valid  <= c1.valid;
      c3.valid  <= c2.valid;
      out_valid <= c3.valid;
    end
    if (en) begin
      c1.op  <= in_ctl.op;
      c1.err <= in_ctl.err;
      p1     <= bis_pkg::blend_prod(pa, pb, fy);
      p2     <= bis_pkg::blend_prod(pc, pd, fy);
      a1     <= pa;
      c1v    <= pc;
      fx1    <= fx;

      c2.op  <= c1.op;
      c2.err <= c1.err;
      m1     <= bis_pkg::blend_fin(a1, p1);
      m2     <= bis_pkg::blend_fin(c1v, p2);
      fx2    <= fx1;

      c3.op  <= c2.op;
      c3.err <= c2.err;
      p3     <= bis_pkg::blend_prod(m1, m2, fx2);
      m1d    <= m1;

      out_err   <= c3.err;
      out_pixel <= c3.err ? '0 : bis_pkg::blend_fin(m1d, p3);
    end
  end

endmodule

// ===== src/bis_checker.sv =====
// Port-level checks of the bilinear image scaler, bound to its top level.
// Depends on bis_pkg and bilinear_image_scaler_top.
`timescale 1ns / 1ps
module bis_port_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bis_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                           m_tuser,
  input logic                           pready
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error result carries a nonzero pixel");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("configuration port not ready");

endmodule

bind bilinear_image_scaler_top bis_port_checker u_bis_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);
